// ===== hw/rtl/msbe_pkg.sv =====
// Shared sizes and arithmetic-unit interface types for the stack bytecode evaluator.
package msbe_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int NUM_VARS    = 16;
    localparam int NUM_CONSTS  = 16;
    localparam int BYTE_BITS   = 8;

    localparam int WORD_W = 64;
    localparam int RES_W  = 63;

    localparam int SP_AW  = $clog2(STACK_DEPTH);
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int VAR_AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int CON_AW = (NUM_CONSTS > 1) ? $clog2(NUM_CONSTS) : 1;
    localparam int ALU_CW = $clog2(WORD_W + 1);

    typedef enum logic {
        ALU_DIV,
        ALU_MUL
    } alu_op_t;

    typedef struct packed {
        logic             start;
        alu_op_t          op;
        logic [WORD_W-1:0] a;
        logic [RES_W-1:0]  b;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quo;
        logic [RES_W-1:0]  rem;
        logic [RES_W-1:0]  prod;
    } alu_rsp_t;

endpackage

// ===== hw/rtl/msbe_alu.sv =====
// Shared iterative unit: restoring divide and modular shift-add multiply.
module msbe_alu
    import msbe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  alu_req_t         req,
    input  logic [RES_W-1:0] modulus,
    output alu_rsp_t         rsp
);

    logic              busy_reg;
    logic              done_reg;
    alu_op_t           op_reg;
    logic [ALU_CW-1:0] cnt_reg;
    logic [WORD_W-1:0] n_reg;
    logic [WORD_W-1:0] q_reg;
    logic [RES_W-1:0]  rem_reg;
    logic [RES_W-1:0]  d_reg;
    logic [RES_W-1:0]  x_reg;
    logic [RES_W-1:0]  y_reg;
    logic [RES_W-1:0]  acc_reg;

    logic [WORD_W-1:0] div_t;
    logic [WORD_W-1:0] div_sub;
    logic              div_ge;
    logic [RES_W-1:0]  rem_step;
    logic [WORD_W-1:0] sum_a;
    logic [WORD_W-1:0] sum_x;
    logic [RES_W-1:0]  acc_step;
    logic [RES_W-1:0]  x_step;
    logic              small_mod;

    assign small_mod = (modulus < RES_W'(2));
    assign div_t     = {rem_reg, n_reg[WORD_W-1]};
    assign div_ge    = (div_t >= {1'b0, d_reg});
    assign div_sub   = div_t - {1'b0, d_reg};
    assign rem_step  = div_ge ? div_sub[RES_W-1:0] : div_t[RES_W-1:0];

    always_comb
    begin
        logic [WORD_W-1:0] ra;
        logic [WORD_W-1:0] rx;
        sum_a    = {1'b0, acc_reg} + {1'b0, x_reg};
        sum_x    = {1'b0, x_reg} + {1'b0, x_reg};
        ra       = sum_a - {1'b0, modulus};
        rx       = sum_x - {1'b0, modulus};
        acc_step = (sum_a >= {1'b0, modulus}) ? ra[RES_W-1:0] : sum_a[RES_W-1:0];
        x_step   = (sum_x >= {1'b0, modulus}) ? rx[RES_W-1:0] : sum_x[RES_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (req.start)
                begin
                    busy_reg <= 1'b1;
                    op_reg   <= req.op;
                    cnt_reg  <= ALU_CW'(WORD_W);
                end
            end
            else if (op_reg == ALU_DIV)
            begin
                cnt_reg <= cnt_reg - ALU_CW'(1);
                if (cnt_reg == ALU_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (y_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (!busy_reg)
        begin
            if (req.start)
            begin
                n_reg   <= req.a;
                d_reg   <= req.b;
                rem_reg <= '0;
                q_reg   <= '0;
                x_reg   <= req.a[RES_W-1:0];
                y_reg   <= req.b;
                acc_reg <= '0;
            end
        end
        else if (op_reg == ALU_DIV)
        begin
            rem_reg <= rem_step;
            q_reg   <= {q_reg[WORD_W-2:0], div_ge};
            n_reg   <= {n_reg[WORD_W-2:0], 1'b0};
        end
        else if (y_reg != '0)
        begin
            if (y_reg[0])
            begin
                acc_reg <= acc_step;
            end
            x_reg <= x_step;
            y_reg <= {1'b0, y_reg[RES_W-1:1]};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = q_reg;
    assign rsp.rem  = small_mod ? '0 : rem_reg;
    assign rsp.prod = small_mod ? '0 : acc_reg;

endmodule

// ===== hw/rtl/modular_stack_bytecode_evaluator_top.sv =====
// Top level of the modular stack bytecode evaluator.
// Usage:
//   Input channel (in_valid/in_ready): one beat is one command. command 0 and 1
//   load a variable or constant slot with word reduced by the modulus; command 2
//   carries one bytecode byte. in_ready is high only while the sequencer is idle.
//   Output channel (out_valid/out_ready): one beat per END opcode, carrying the
//   popped value and status. A held result sits in the output register while new
//   beats are accepted; a second END waits until that register is free.
//   Config channel (cfg_valid/cfg_ready): always ready, writes the modulus; write
//   only while the block is idle.
// Sequencing per input beat, all divides and multiplies on one shared unit:
//   literal, VAR/BIGNUM and unknown opcodes finish in the idle state. Slot
//   writes and NEG wait for a reduction. END passes the emit state to the output
//   register. ADD/MUL fold n terms. POW squares per exponent bit (up to 64 bits)
//   and multiplies per set bit; NEGPOW adds an extended Euclid pass.
// Reset clears the stack pointer, decoder, error flag and sets the modulus to 2.
module modular_stack_bytecode_evaluator_top
    import msbe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    input  logic [7:0]        slot,
    input  logic [RES_W-1:0]  word,
    input  logic [7:0]        code_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] value,
    output logic [1:0]        status,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [RES_W-1:0]  cfg_data
);

    localparam logic [1:0] CMD_VAR   = 2'd0;
    localparam logic [1:0] CMD_CONST = 2'd1;
    localparam logic [1:0] CMD_CODE  = 2'd2;

    localparam logic [7:0] OP_END      = 8'd0;
    localparam logic [7:0] OP_ADD      = 8'd1;
    localparam logic [7:0] OP_MUL      = 8'd2;
    localparam logic [7:0] OP_NEG      = 8'd3;
    localparam logic [7:0] OP_POW      = 8'd4;
    localparam logic [7:0] OP_VAR      = 8'd5;
    localparam logic [7:0] OP_NEGPOW   = 8'd6;
    localparam logic [7:0] OP_SMALLNUM = 8'd7;
    localparam logic [7:0] OP_MEDNUM   = 8'd8;
    localparam logic [7:0] OP_BIGNUM   = 8'd9;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INV   = 2'd1;
    localparam logic [1:0] ST_STACK = 2'd2;

    localparam logic [8:0] VAR_LIM = 9'(NUM_VARS);
    localparam logic [8:0] CON_LIM = 9'(NUM_CONSTS);

    typedef enum logic [4:0] {
        S_IDLE, S_EMIT, S_TAB, S_NEG,
        S_NCNT, S_NLD, S_NRED, S_NMUL, S_NFIN,
        S_PRED, S_PSTEP, S_PMR, S_PMB, S_PFIN,
        S_ESTEP, S_EDIV, S_EMUL
    } state_t;

    typedef enum logic [1:0] {
        PH_OP, PH_SMALL, PH_LEN, PH_LIT
    } phase_t;

    state_t            state_reg;
    phase_t            phase_reg;
    logic [7:0]        lit_left_reg;
    logic [WORD_W-1:0] lit_acc_reg;
    logic [1:0]        err_reg;
    logic [SP_W-1:0]   sp_reg;
    logic [RES_W-1:0]  mod_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] value_reg;
    logic [1:0]        status_reg;
    logic [WORD_W-1:0] pend_value_reg;
    logic [1:0]        pend_status_reg;
    logic              is_mul_reg;
    logic              is_neg_reg;
    logic              first_reg;
    logic [SP_W-1:0]   k_reg;
    logic [SP_AW-1:0]  idx_reg;
    logic [SP_AW-1:0]  base_reg;
    logic [RES_W-1:0]  acc_reg;
    logic [RES_W-1:0]  bval_reg;
    logic [WORD_W-1:0] e_reg;
    logic [RES_W-1:0]  r0_reg;
    logic [RES_W-1:0]  r1_reg;
    logic [RES_W-1:0]  t0_reg;
    logic [RES_W-1:0]  t1_reg;
    logic [7:0]        slot_reg;
    logic              tab_var_reg;

    logic [WORD_W-1:0] stk_mem [STACK_DEPTH];
    logic [RES_W-1:0]  var_mem [NUM_VARS];
    logic [RES_W-1:0]  con_mem [NUM_CONSTS];

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    logic              accept_in;
    logic              code_in;
    logic              op_in;
    logic              err_ok;
    logic              msmall;
    logic              push_full;
    logic [SP_W-1:0]   sp_m1;
    logic [SP_W-1:0]   sp_m2;
    logic [SP_AW-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              var_ok;
    logic              con_ok;
    logic [WORD_W-1:0] lit_shift;
    logic [7:0]        lit_left_m1;
    logic [SP_W-1:0]   cnt_n;
    logic [RES_W-1:0]  add_red;
    logic [RES_W-1:0]  neg_val;
    logic [RES_W-1:0]  sub_val;
    logic [RES_W-1:0]  q_red;
    logic              stk_we;
    logic [SP_AW-1:0]  stk_wa;
    logic [WORD_W-1:0] stk_wd;

    msbe_alu u_alu (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (alu_req),
        .modulus (mod_reg),
        .rsp     (alu_rsp)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign status      = status_reg;

    assign accept_in   = in_valid && in_ready;
    assign code_in     = accept_in && (command == CMD_CODE);
    assign op_in       = code_in && (phase_reg == PH_OP);
    assign err_ok      = (err_reg == ST_OK);
    assign msmall      = (mod_reg < RES_W'(2));
    assign push_full   = (sp_reg >= SP_W'(STACK_DEPTH));
    assign sp_m1       = sp_reg - SP_W'(1);
    assign sp_m2       = sp_reg - SP_W'(2);
    assign rd_data     = stk_mem[rd_addr];
    assign var_ok      = (rd_data < WORD_W'(NUM_VARS));
    assign con_ok      = (rd_data < WORD_W'(NUM_CONSTS));
    assign lit_shift   = {lit_acc_reg[WORD_W-BYTE_BITS-1:0], code_byte};
    assign lit_left_m1 = lit_left_reg - 8'd1;
    assign cnt_n       = rd_data[SP_W-1:0];

    always_comb
    begin
        logic [WORD_W-1:0] s;
        logic [WORD_W-1:0] sr;
        s       = {1'b0, acc_reg} + {1'b0, alu_rsp.rem};
        sr      = s - {1'b0, mod_reg};
        add_red = msmall ? '0 :
                  ((s >= {1'b0, mod_reg}) ? sr[RES_W-1:0] : s[RES_W-1:0]);
        neg_val = (msmall || alu_rsp.rem == '0) ? '0 : mod_reg - alu_rsp.rem;
        sub_val = (t0_reg >= alu_rsp.prod) ? t0_reg - alu_rsp.prod
                                           : (mod_reg - alu_rsp.prod) + t0_reg;
        q_red   = (alu_rsp.quo == {1'b0, mod_reg}) ? '0 : alu_rsp.quo[RES_W-1:0];
    end

    always_comb
    begin
        unique case (state_reg)
            S_PRED:  rd_addr = sp_m2[SP_AW-1:0];
            S_NLD:   rd_addr = idx_reg;
            default: rd_addr = sp_m1[SP_AW-1:0];
        endcase
    end

    // stack write port and shared-unit launch
    always_comb
    begin
        stk_we        = 1'b0;
        stk_wa        = sp_reg[SP_AW-1:0];
        stk_wd        = '0;
        alu_req.start = 1'b0;
        alu_req.op    = ALU_DIV;
        alu_req.a     = rd_data;
        alu_req.b     = mod_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in && (command == CMD_VAR || command == CMD_CONST))
                begin
                    alu_req.start = 1'b1;
                    alu_req.a     = {1'b0, word};
                end
                else if (code_in)
                begin
                    unique case (phase_reg)
                        PH_SMALL:
                        begin
                            stk_we = err_ok && !push_full;
                            stk_wd = {{(WORD_W-8){1'b0}}, code_byte};
                        end
                        PH_LEN:
                        begin
                            stk_we = err_ok && !push_full && (code_byte == 8'd0);
                        end
                        PH_LIT:
                        begin
                            stk_we = err_ok && !push_full && (lit_left_m1 == 8'd0);
                            stk_wd = lit_shift;
                        end
                        PH_OP:
                        begin
                            if (err_ok && sp_reg != '0)
                            begin
                                stk_wa = sp_m1[SP_AW-1:0];
                                if (code_byte == OP_VAR && var_ok)
                                begin
                                    stk_we = 1'b1;
                                    stk_wd = {1'b0, var_mem[rd_data[VAR_AW-1:0]]};
                                end
                                else if (code_byte == OP_BIGNUM && con_ok)
                                begin
                                    stk_we = 1'b1;
                                    stk_wd = {1'b0, con_mem[rd_data[CON_AW-1:0]]};
                                end
                                else if (code_byte == OP_NEG)
                                begin
                                    alu_req.start = 1'b1;
                                end
                                else if ((code_byte == OP_POW || code_byte == OP_NEGPOW)
                                         && sp_reg >= SP_W'(2))
                                begin
                                    alu_req.start = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_NLD:
            begin
                alu_req.start = 1'b1;
            end
            S_NRED:
            begin
                if (alu_rsp.done && !first_reg && is_mul_reg)
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = ALU_MUL;
                    alu_req.a     = {1'b0, acc_reg};
                    alu_req.b     = alu_rsp.rem;
                end
            end
            S_NFIN:
            begin
                stk_we = 1'b1;
                stk_wa = base_reg;
                stk_wd = {1'b0, acc_reg};
            end
            S_NEG:
            begin
                stk_we = alu_rsp.done;
                stk_wa = sp_m1[SP_AW-1:0];
                stk_wd = {1'b0, neg_val};
            end
            S_PSTEP:
            begin
                alu_req.start = (e_reg != '0);
                alu_req.op    = ALU_MUL;
                alu_req.a     = {1'b0, (e_reg[0] ? acc_reg : bval_reg)};
                alu_req.b     = bval_reg;
            end
            S_PMR:
            begin
                alu_req.start = alu_rsp.done;
                alu_req.op    = ALU_MUL;
                alu_req.a     = {1'b0, bval_reg};
                alu_req.b     = bval_reg;
            end
            S_PFIN:
            begin
                stk_we = !is_neg_reg;
                stk_wa = sp_m2[SP_AW-1:0];
                stk_wd = {1'b0, acc_reg};
            end
            S_ESTEP:
            begin
                stk_wa = sp_m2[SP_AW-1:0];
                stk_wd = {1'b0, t0_reg};
                if (r1_reg == '0)
                begin
                    stk_we = (r0_reg == RES_W'(1));
                end
                else
                begin
                    alu_req.start = 1'b1;
                    alu_req.a     = {1'b0, r0_reg};
                    alu_req.b     = r1_reg;
                end
            end
            S_EDIV:
            begin
                alu_req.start = alu_rsp.done;
                alu_req.op    = ALU_MUL;
                alu_req.a     = {1'b0, q_red};
                alu_req.b     = t1_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        if (state_reg == S_TAB && alu_rsp.done)
        begin
            if (tab_var_reg && {1'b0, slot_reg} < VAR_LIM)
            begin
                var_mem[slot_reg[VAR_AW-1:0]] <= alu_rsp.rem;
            end
            if (!tab_var_reg && {1'b0, slot_reg} < CON_LIM)
            begin
                con_mem[slot_reg[CON_AW-1:0]] <= alu_rsp.rem;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_OP;
            lit_left_reg  <= '0;
            lit_acc_reg   <= '0;
            err_reg       <= ST_OK;
            sp_reg        <= '0;
            mod_reg       <= RES_W'(2);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mod_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept_in && (command == CMD_VAR || command == CMD_CONST))
                    begin
                        slot_reg    <= slot;
                        tab_var_reg <= (command == CMD_VAR);
                        state_reg   <= S_TAB;
                    end
                    else if (code_in)
                    begin
                        unique case (phase_reg)
                            PH_SMALL:
                            begin
                                phase_reg <= PH_OP;
                                if (err_ok)
                                begin
                                    if (push_full) err_reg <= ST_STACK;
                                    else sp_reg <= sp_reg + SP_W'(1);
                                end
                            end
                            PH_LEN:
                            begin
                                lit_left_reg <= code_byte;
                                lit_acc_reg  <= '0;
                                if (code_byte == 8'd0)
                                begin
                                    phase_reg <= PH_OP;
                                    if (err_ok)
                                    begin
                                        if (push_full) err_reg <= ST_STACK;
                                        else sp_reg <= sp_reg + SP_W'(1);
                                    end
                                end
                                else
                                begin
                                    phase_reg <= PH_LIT;
                                end
                            end
                            PH_LIT:
                            begin
                                lit_acc_reg  <= lit_shift;
                                lit_left_reg <= lit_left_m1;
                                if (lit_left_m1 == 8'd0)
                                begin
                                    phase_reg <= PH_OP;
                                    if (err_ok)
                                    begin
                                        if (push_full) err_reg <= ST_STACK;
                                        else sp_reg <= sp_reg + SP_W'(1);
                                    end
                                end
                            end
                            PH_OP:
                            begin
                                priority if (code_byte == OP_END)
                                begin
                                    pend_value_reg  <= (err_ok && sp_reg != '0) ? rd_data : '0;
                                    pend_status_reg <= !err_ok ? err_reg :
                                                       ((sp_reg == '0) ? ST_STACK : ST_OK);
                                    sp_reg    <= '0;
                                    err_reg   <= ST_OK;
                                    state_reg <= S_EMIT;
                                end
                                else if (code_byte == OP_SMALLNUM)
                                begin
                                    phase_reg <= PH_SMALL;
                                end
                                else if (code_byte == OP_MEDNUM)
                                begin
                                    phase_reg <= PH_LEN;
                                end
                                else if (!err_ok)
                                begin
                                end
                                else if (code_byte == OP_ADD || code_byte == OP_MUL)
                                begin
                                    is_mul_reg <= (code_byte == OP_MUL);
                                    if (sp_reg == '0) err_reg <= ST_STACK;
                                    else state_reg <= S_NCNT;
                                end
                                else if (code_byte == OP_NEG)
                                begin
                                    if (sp_reg == '0) err_reg <= ST_STACK;
                                    else state_reg <= S_NEG;
                                end
                                else if (code_byte == OP_POW || code_byte == OP_NEGPOW)
                                begin
                                    is_neg_reg <= (code_byte == OP_NEGPOW);
                                    if (sp_reg < SP_W'(2)) err_reg <= ST_STACK;
                                    else state_reg <= S_PRED;
                                end
                                else if (code_byte == OP_VAR)
                                begin
                                    if (sp_reg == '0 || !var_ok) err_reg <= ST_STACK;
                                end
                                else if (code_byte == OP_BIGNUM)
                                begin
                                    if (sp_reg == '0 || !con_ok) err_reg <= ST_STACK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        value_reg     <= pend_value_reg;
                        status_reg    <= pend_status_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                S_TAB, S_NEG:
                begin
                    if (alu_rsp.done) state_reg <= S_IDLE;
                end
                S_NCNT:
                begin
                    if (rd_data == '0 || rd_data > WORD_W'(sp_m1))
                    begin
                        err_reg   <= ST_STACK;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        sp_reg    <= sp_m1;
                        k_reg     <= cnt_n - SP_W'(1);
                        idx_reg   <= SP_AW'(sp_m1 - SP_W'(1));
                        base_reg  <= SP_AW'(sp_m1 - cnt_n);
                        first_reg <= 1'b1;
                        state_reg <= (cnt_n == SP_W'(1)) ? S_IDLE : S_NLD;
                    end
                end
                S_NLD:
                begin
                    state_reg <= S_NRED;
                end
                S_NRED:
                begin
                    if (alu_rsp.done)
                    begin
                        if (first_reg)
                        begin
                            acc_reg   <= alu_rsp.rem;
                            first_reg <= 1'b0;
                            idx_reg   <= idx_reg - SP_AW'(1);
                            state_reg <= S_NLD;
                        end
                        else if (is_mul_reg)
                        begin
                            state_reg <= S_NMUL;
                        end
                        else
                        begin
                            acc_reg   <= add_red;
                            k_reg     <= k_reg - SP_W'(1);
                            idx_reg   <= idx_reg - SP_AW'(1);
                            state_reg <= (k_reg == SP_W'(1)) ? S_NFIN : S_NLD;
                        end
                    end
                end
                S_NMUL:
                begin
                    if (alu_rsp.done)
                    begin
                        acc_reg   <= alu_rsp.prod;
                        k_reg     <= k_reg - SP_W'(1);
                        idx_reg   <= idx_reg - SP_AW'(1);
                        state_reg <= (k_reg == SP_W'(1)) ? S_NFIN : S_NLD;
                    end
                end
                S_NFIN:
                begin
                    sp_reg    <= SP_W'(base_reg) + SP_W'(1);
                    state_reg <= S_IDLE;
                end
                S_PRED:
                begin
                    e_reg <= rd_data;
                    if (alu_rsp.done)
                    begin
                        bval_reg <= alu_rsp.rem;
                        acc_reg  <= msmall ? '0 : RES_W'(1);
                        if (is_neg_reg && alu_rsp.rem == '0)
                        begin
                            err_reg   <= ST_INV;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_PSTEP;
                        end
                    end
                end
                S_PSTEP:
                begin
                    priority if (e_reg == '0) state_reg <= S_PFIN;
                    else if (e_reg[0])        state_reg <= S_PMR;
                    else                      state_reg <= S_PMB;
                end
                S_PMR:
                begin
                    if (alu_rsp.done)
                    begin
                        acc_reg   <= alu_rsp.prod;
                        state_reg <= S_PMB;
                    end
                end
                S_PMB:
                begin
                    if (alu_rsp.done)
                    begin
                        bval_reg  <= alu_rsp.prod;
                        e_reg     <= {1'b0, e_reg[WORD_W-1:1]};
                        state_reg <= S_PSTEP;
                    end
                end
                S_PFIN:
                begin
                    if (!is_neg_reg)
                    begin
                        sp_reg    <= sp_m1;
                        state_reg <= S_IDLE;
                    end
                    else if (acc_reg == '0)
                    begin
                        err_reg   <= ST_INV;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        r0_reg    <= mod_reg;
                        r1_reg    <= acc_reg;
                        t0_reg    <= '0;
                        t1_reg    <= RES_W'(1);
                        state_reg <= S_ESTEP;
                    end
                end
                S_ESTEP:
                begin
                    if (r1_reg == '0)
                    begin
                        if (r0_reg == RES_W'(1)) sp_reg <= sp_m1;
                        else err_reg <= ST_INV;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_EDIV;
                    end
                end
                S_EDIV:
                begin
                    if (alu_rsp.done)
                    begin
                        r0_reg    <= r1_reg;
                        r1_reg    <= alu_rsp.rem;
                        state_reg <= S_EMUL;
                    end
                end
                S_EMUL:
                begin
                    if (alu_rsp.done)
                    begin
                        t0_reg    <= t1_reg;
                        t1_reg    <= sub_val;
                        state_reg <= S_ESTEP;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (op_in && code_byte == OP_END) |=>
            (sp_reg == '0 && err_reg == ST_OK && state_reg == S_EMIT))
        else $error("END did not clear stack and flag");

    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == ST_OK || value_reg == '0))
        else $error("flagged result carries nonzero value");

    a_alu_owner: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg != S_IDLE && state_reg != S_EMIT))
        else $error("arithmetic unit finished with no waiting step");

endmodule

// ===== tb/modular_stack_bytecode_evaluator_checker.sv =====
// Checker that predicts and compares the result beats of the stack bytecode evaluator.
`timescale 1ns / 100ps
module modular_stack_bytecode_evaluator_checker
    import msbe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [1:0]        command,
    input  logic [7:0]        slot,
    input  logic [RES_W-1:0]  word,
    input  logic [7:0]        code_byte,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [WORD_W-1:0] value,
    input  logic [1:0]        status,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [RES_W-1:0]  cfg_data,
    output int                fail_count,
    output int                pending_count
);

    localparam logic [7:0] OP_END      = 8'd0;
    localparam logic [7:0] OP_ADD      = 8'd1;
    localparam logic [7:0] OP_MUL      = 8'd2;
    localparam logic [7:0] OP_NEG      = 8'd3;
    localparam logic [7:0] OP_POW      = 8'd4;
    localparam logic [7:0] OP_VAR      = 8'd5;
    localparam logic [7:0] OP_NEGPOW   = 8'd6;
    localparam logic [7:0] OP_SMALLNUM = 8'd7;
    localparam logic [7:0] OP_MEDNUM   = 8'd8;
    localparam logic [7:0] OP_BIGNUM   = 8'd9;

    localparam logic [1:0] CMD_VAR   = 2'd0;
    localparam logic [1:0] CMD_CONST = 2'd1;
    localparam logic [1:0] CMD_CODE  = 2'd2;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_INV = 2'd1;
    localparam logic [1:0] ST_STK = 2'd2;

    localparam logic [1:0] PH_OPCODE = 2'd0;
    localparam logic [1:0] PH_SMALL  = 2'd1;
    localparam logic [1:0] PH_LEN    = 2'd2;
    localparam logic [1:0] PH_BYTES  = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [1:0]        status;
    } eval_result_t;

    eval_result_t result_q[$];

    logic [63:0] prime;
    logic [63:0] stk[STACK_DEPTH];
    int unsigned sp;
    logic [1:0]  phase;
    logic [7:0]  bytes_left;
    logic [63:0] lit_acc;
    logic [1:0]  err;
    logic [63:0] vars[NUM_VARS];
    logic [63:0] consts[NUM_CONSTS];

    function automatic logic [63:0] mod_red(logic [63:0] x);
        if (prime < 2) return 0;
        return x % prime;
    endfunction

    function automatic logic [63:0] mod_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (prime < 2) return 0;
        if (s >= prime) s = s - prime;
        return s;
    endfunction

    function automatic logic [63:0] mod_sub(logic [63:0] a, logic [63:0] b);
        if (prime < 2) return 0;
        return (a >= b) ? a - b : (prime - b) + a;
    endfunction

    function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        if (prime < 2) return 0;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p % {64'd0, prime});
    endfunction

    function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] e);
        logic [63:0] r;
        r = mod_red(64'd1);
        while (e != 0)
        begin
            if (e[0]) r = mod_mul(r, base);
            base = mod_mul(base, base);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic logic [63:0] mod_inv(logic [63:0] x, output bit ok);
        logic [63:0] r0, r1, t0, t1, q, nr, nt;
        r0 = prime;
        r1 = x;
        t0 = 0;
        t1 = mod_red(64'd1);
        ok = 0;
        if (prime < 2 || x == 0) return 0;
        while (r1 != 0)
        begin
            q = r0 / r1;
            nr = r0 - q * r1;
            nt = mod_sub(t0, mod_mul(mod_red(q), t1));
            r0 = r1;
            r1 = nr;
            t0 = t1;
            t1 = nt;
        end
        if (r0 != 1) return 0;
        ok = 1;
        return t0;
    endfunction

    function automatic void raise_flag(logic [1:0] code);
        if (err == ST_OK) err = code;
    endfunction

    function automatic void stack_push(logic [63:0] v);
        if (sp >= STACK_DEPTH)
        begin
            raise_flag(ST_STK);
            return;
        end
        stk[sp] = v;
        sp++;
    endfunction

    function automatic void fold_terms(bit is_mul);
        logic [63:0] cnt, acc, t;
        if (sp < 1)
        begin
            raise_flag(ST_STK);
            return;
        end
        sp--;
        cnt = stk[sp];
        if (cnt == 0 || cnt > sp)
        begin
            raise_flag(ST_STK);
            return;
        end
        acc = stk[sp-1];
        if (cnt > 1)
        begin
            acc = mod_red(acc);
            for (int k = 1; k < cnt; k++)
            begin
                t = mod_red(stk[sp-1-k]);
                acc = is_mul ? mod_mul(acc, t) : mod_add(acc, t);
            end
        end
        sp = sp - int'(cnt);
        stack_push(acc);
    endfunction

    function automatic void run_opcode(logic [7:0] op);
        logic [63:0] a, b, r;
        bit ok;
        case (op)
            OP_ADD: fold_terms(0);
            OP_MUL: fold_terms(1);
            OP_NEG:
            begin
                if (sp < 1) raise_flag(ST_STK);
                else stk[sp-1] = mod_sub(0, mod_red(stk[sp-1]));
            end
            OP_POW, OP_NEGPOW:
            begin
                if (sp < 2)
                begin
                    raise_flag(ST_STK);
                    return;
                end
                a = mod_red(stk[sp-1]);
                b = stk[sp-2];
                sp -= 2;
                r = mod_pow(a, b);
                if (op == OP_NEGPOW)
                begin
                    if (a == 0)
                    begin
                        raise_flag(ST_INV);
                        return;
                    end
                    r = mod_inv(r, ok);
                    if (!ok)
                    begin
                        raise_flag(ST_INV);
                        return;
                    end
                end
                stack_push(r);
            end
            OP_VAR, OP_BIGNUM:
            begin
                if (sp < 1)
                begin
                    raise_flag(ST_STK);
                    return;
                end
                a = stk[sp-1];
                if (op == OP_VAR)
                begin
                    if (a >= NUM_VARS) raise_flag(ST_STK);
                    else stk[sp-1] = vars[a];
                end
                else
                begin
                    if (a >= NUM_CONSTS) raise_flag(ST_STK);
                    else stk[sp-1] = consts[a];
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_beat(logic [1:0] cmd, logic [7:0] sl, logic [62:0] w,
                                         logic [7:0] b);
        eval_result_t r;
        if (cmd == CMD_VAR)
        begin
            if (sl < NUM_VARS) vars[sl] = mod_red({1'b0, w});
            return;
        end
        if (cmd == CMD_CONST)
        begin
            if (sl < NUM_CONSTS) consts[sl] = mod_red({1'b0, w});
            return;
        end
        if (cmd != CMD_CODE) return;
        case (phase)
            PH_SMALL:
            begin
                phase = PH_OPCODE;
                if (err == ST_OK) stack_push({56'd0, b});
                return;
            end
            PH_LEN:
            begin
                bytes_left = b;
                lit_acc = 0;
                if (b == 0)
                begin
                    phase = PH_OPCODE;
                    if (err == ST_OK) stack_push(0);
                end
                else phase = PH_BYTES;
                return;
            end
            PH_BYTES:
            begin
                lit_acc = (lit_acc << 8) | {56'd0, b};
                bytes_left = bytes_left - 1;
                if (bytes_left == 0)
                begin
                    phase = PH_OPCODE;
                    if (err == ST_OK) stack_push(lit_acc);
                end
                return;
            end
            default: ;
        endcase
        if (b == OP_END)
        begin
            r.value = 0;
            if (err == ST_OK)
            begin
                if (sp == 0) err = ST_STK;
                else r.value = stk[sp-1];
            end
            r.status = err;
            result_q.push_back(r);
            sp = 0;
            err = ST_OK;
            return;
        end
        if (b == OP_SMALLNUM) phase = PH_SMALL;
        else if (b == OP_MEDNUM) phase = PH_LEN;
        else if (err == ST_OK) run_opcode(b);
    endfunction

    assign pending_count = result_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        eval_result_t exp_r;
        if (!rst_n)
        begin
            prime = 2;
            sp = 0;
            phase = PH_OPCODE;
            bytes_left = 0;
            lit_acc = 0;
            err = ST_OK;
            fail_count = 0;
            result_q.delete();
            for (int i = 0; i < STACK_DEPTH; i++) stk[i] = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) prime = {1'b0, cfg_data};
            if (in_valid && in_ready) predict_beat(command, slot, word, code_byte);
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat: value=%h status=%0d", value, status);
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (exp_r.value !== value || exp_r.status !== status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp value=%h status=%0d, got value=%h status=%0d",
                                     exp_r.value, exp_r.status, value, status);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_modular_stack_bytecode_evaluator_top.sv =====
// Stimulus and verdict for the stack bytecode evaluator testbench.
`timescale 1ns / 100ps
module tb_modular_stack_bytecode_evaluator_top;
    import msbe_pkg::*;

    localparam logic [7:0] OP_END      = 8'd0;
    localparam logic [7:0] OP_ADD      = 8'd1;
    localparam logic [7:0] OP_MUL      = 8'd2;
    localparam logic [7:0] OP_NEG      = 8'd3;
    localparam logic [7:0] OP_POW      = 8'd4;
    localparam logic [7:0] OP_VAR      = 8'd5;
    localparam logic [7:0] OP_NEGPOW   = 8'd6;
    localparam logic [7:0] OP_SMALLNUM = 8'd7;
    localparam logic [7:0] OP_MEDNUM   = 8'd8;
    localparam logic [7:0] OP_BIGNUM   = 8'd9;

    localparam logic [1:0] CMD_VAR   = 2'd0;
    localparam logic [1:0] CMD_CONST = 2'd1;
    localparam logic [1:0] CMD_CODE  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam int STALL_LIMIT = 200000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        command;
    logic [7:0]        slot;
    logic [RES_W-1:0]  word;
    logic [7:0]        code_byte;
    logic              out_valid;
    logic              out_ready;
    logic [WORD_W-1:0] value;
    logic [1:0]        status;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [RES_W-1:0]  cfg_data;

    int fail_count;
    int pending_count;
    int send_idle_pct;
    int recv_stall_pct;
    bit recv_hold;
    int quiet_cycles;

    modular_stack_bytecode_evaluator_top DUT (.*);

    modular_stack_bytecode_evaluator_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (recv_hold) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_modular_stack_bytecode_evaluator_top: FAIL");
            $finish;
        end
    end

    task automatic send_beat(logic [1:0] cmd, logic [7:0] sl, logic [62:0] w, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        slot <= sl;
        word <= w;
        code_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_code(logic [7:0] b);
        send_beat(CMD_CODE, 8'($urandom), 63'({$urandom, $urandom}), b);
    endtask

    task automatic push_small(logic [7:0] b);
        send_code(OP_SMALLNUM);
        send_code(b);
    endtask

    task automatic push_wide(logic [63:0] v, int len);
        send_code(OP_MEDNUM);
        send_code(8'(len));
        for (int i = len - 1; i >= 0; i--) send_code(v[8*(i%8) +: 8]);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_prime(logic [62:0] p);
        integer k;
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= p;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        for (k = 0; k < 16; k++)
            send_beat(k[0] ? CMD_CONST : CMD_VAR, 8'(k / 2), 63'({$urandom, $urandom}), 8'd0);
        for (k = 0; k < 16; k++)
        begin
            send_beat(CMD_VAR, 8'(k), 63'({$urandom, $urandom}), 8'd0);
            send_beat(CMD_CONST, 8'(k), 63'({$urandom, $urandom}), 8'd0);
        end
    endtask

    // one random well-formed expression, with occasional damage
    task automatic random_expr;
        int depth;
        int steps;
        int sel;
        int n;
        depth = 0;
        steps = $urandom_range(1, 8);
        for (int s = 0; s < steps; s++)
        begin
            sel = $urandom_range(0, 11);
            if (depth < 2 || sel < 4)
            begin
                if ($urandom_range(1)) push_small(8'($urandom));
                else push_wide({$urandom, $urandom}, $urandom_range(0, 9));
                depth++;
            end
            else if (sel < 6)
            begin
                n = $urandom_range(1, depth);
                push_small(8'(n));
                send_code($urandom_range(1) ? OP_ADD : OP_MUL);
                depth = depth - n + 1;
            end
            else if (sel == 6) send_code(OP_NEG);
            else if (sel < 9)
            begin
                push_small(8'($urandom_range(0, 20)));
                push_small(8'($urandom));
                send_code($urandom_range(1) ? OP_POW : OP_NEGPOW);
                depth = depth + 2 - 1;
            end
            else if (sel < 11)
            begin
                push_small(8'($urandom_range(0, 15)));
                send_code($urandom_range(1) ? OP_VAR : OP_BIGNUM);
                depth++;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0: send_code(8'($urandom_range(10, 255)));
                    1: send_code(8'($urandom_range(1, 6)));
                    2: push_small(8'($urandom_range(16, 255)));
                    3: send_beat(CMD_NONE, 8'($urandom), 63'({$urandom, $urandom}),
                                 8'($urandom));
                    default: send_beat(CMD_VAR, 8'($urandom_range(16, 255)),
                                       63'({$urandom, $urandom}), 8'($urandom));
                endcase
            end
            if (depth > 14) break;
        end
        send_code(OP_END);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = '0;
        slot = '0;
        word = '0;
        code_byte = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        recv_hold = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        set_prime(63'd1000003);
        push_small(8'd255);
        push_small(8'd3);
        push_small(8'd2);
        send_code(OP_ADD);
        send_code(OP_END);
        push_wide(64'hFFFF_FFFF_FFFF_FFFF, 9);
        send_code(OP_NEG);
        send_code(OP_END);
        push_small(8'd0);
        push_small(8'd0);
        send_code(OP_NEGPOW);
        send_code(OP_END);
        send_code(OP_END);
        push_small(8'd0);
        send_code(OP_MUL);
        send_code(OP_END);
        push_small(8'd16);
        send_code(OP_VAR);
        send_code(OP_END);
        for (int i = 0; i < 17; i++) push_small(8'd1);
        send_code(OP_END);
        push_wide(64'd0, 0);
        send_code(8'd200);
        send_code(OP_END);

        set_prime(63'h7FFF_FFFF_FFFF_FFFF);
        push_wide(64'h7FFF_FFFF_FFFF_FFFE, 8);
        push_small(8'd3);
        send_code(OP_BIGNUM);
        send_code(OP_END);
        set_prime(63'd0);
        push_small(8'd1);
        push_small(8'd5);
        send_code(OP_NEGPOW);
        send_code(OP_END);

        // random, idling phases
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            case (ph)
                0: set_prime(63'd2);
                1: set_prime(63'd65537);
                2: set_prime(63'h7FFF_FFFF_FFFF_FFE7);
                3: set_prime(63'd101);
                4: set_prime(63'd1);
                5: set_prime(63'd4294967291);
                6: set_prime(63'({$urandom, $urandom}) | 63'd3);
                default: set_prime(63'd7);
            endcase
            if (ph == 2)
            begin
                recv_hold = 1'b1;
                fork
                    begin
                        repeat (3000) @(posedge clk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            for (int e = 0; e < 6; e++) random_expr();
            if (ph == 4) drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        drain();
        if (fail_count == 0)
            $display("tb_modular_stack_bytecode_evaluator_top: PASS");
        else
            $display("tb_modular_stack_bytecode_evaluator_top: FAIL");
        $finish;
    end

endmodule
